// ===== hw/rtl/bfc_pkg.sv =====
package bfc_pkg;

   // plane table
   localparam int NumPlanes = 6;
   localparam int CsrIdxW   = 3;
   localparam int CfgW      = 64;

   // plane register layout
   localparam int CoefW = 13;   // a, b, c: signed Q1.11
   localparam int AOff  = 0;
   localparam int BOff  = 13;
   localparam int COff  = 26;
   localparam int DOff  = 39;
   localparam int DW    = 25;   // d: signed, 8 fraction bits
   localparam int DShift = 12;  // d aligned to 20 fraction bits

   // input fields
   localparam int InW      = 24;
   localparam int EdgeW    = 16;
   localparam int ReqDataW = 88;
   localparam int CyOff    = 24;
   localparam int CzOff    = 48;
   localparam int EdgeOff  = 72;
   localparam int RspDataW = 8;

   // datapath widths
   localparam int CoordW = 26;  // doubled corner coordinate, 9 fraction bits
   localparam int ProdW  = 39;  // coef * coord
   localparam int SumW   = 42;  // three products plus scaled d

   typedef logic signed [CoordW-1:0] coord_type;

   // box extents plus the running reject flag, handed cell to cell
   typedef struct packed {
      coord_type x_lo;
      coord_type x_hi;
      coord_type y_lo;
      coord_type y_hi;
      coord_type z_lo;
      coord_type z_hi;
      logic      reject;
   } box_type;

endpackage

// ===== hw/rtl/bfc_prep.sv =====
module bfc_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [bfc_pkg::ReqDataW-1:0]  in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output bfc_pkg::box_type              out_box
);

   logic signed [bfc_pkg::InW-1:0]  cx, cy, cz;
   logic [bfc_pkg::EdgeW-1:0]       e;
   bfc_pkg::coord_type              cx2, cy2, cz2, e1, e2;

   logic              v_ff, v_in;
   bfc_pkg::box_type  box_ff, box_in;

   assign cx = in_data[bfc_pkg::InW-1:0];
   assign cy = in_data[bfc_pkg::CyOff +: bfc_pkg::InW];
   assign cz = in_data[bfc_pkg::CzOff +: bfc_pkg::InW];
   assign e  = in_data[bfc_pkg::EdgeOff +: bfc_pkg::EdgeW];

   // doubled coordinates keep the half edge exact
   assign cx2 = {cx[bfc_pkg::InW-1], cx, 1'b0};
   assign cy2 = {cy[bfc_pkg::InW-1], cy, 1'b0};
   assign cz2 = {cz[bfc_pkg::InW-1], cz, 1'b0};
   assign e1  = {{(bfc_pkg::CoordW-bfc_pkg::EdgeW){1'b0}}, e};
   assign e2  = {{(bfc_pkg::CoordW-bfc_pkg::EdgeW-1){1'b0}}, e, 1'b0};

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      v_in          = in_ready ? in_valid : v_ff;
      box_in        = box_ff;
      if (in_ready) begin
         box_in.x_lo   = cx2 - e1;
         box_in.x_hi   = cx2 + e1;
         box_in.y_lo   = cy2;
         box_in.y_hi   = cy2 + e2;
         box_in.z_lo   = cz2 - e1;
         box_in.z_hi   = cz2 + e1;
         box_in.reject = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
      box_ff <= box_in;
   end

   assign out_valid = v_ff;
   assign out_box   = box_ff;

endmodule

// ===== hw/rtl/bfc_cell.sv =====
module bfc_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       cfg_we,
   input  logic [bfc_pkg::CfgW-1:0]   cfg_data,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  bfc_pkg::box_type           in_box,
   output logic                       out_valid,
   input  logic                       out_ready,
   output bfc_pkg::box_type           out_box
);

   logic [bfc_pkg::CfgW-1:0]          plane_ff, plane_in;
   logic signed [bfc_pkg::CoefW-1:0]  ca, cb, cc;
   logic signed [bfc_pkg::DW-1:0]     cd;
   bfc_pkg::coord_type                sx, sy, sz;
   logic signed [bfc_pkg::ProdW-1:0]  px, py, pz;
   logic signed [bfc_pkg::SumW-1:0]   dx;

   // multiply stage
   logic                              a_v_ff, a_v_in, a_ready;
   logic signed [bfc_pkg::ProdW-1:0]  px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [bfc_pkg::SumW-1:0]   pd_ff, pd_in;
   bfc_pkg::box_type                  a_box_ff, a_box_in;

   // sum stage
   logic                              b_v_ff, b_v_in, b_ready;
   logic signed [bfc_pkg::SumW-1:0]   sum;
   bfc_pkg::box_type                  b_box_ff, b_box_in;

   assign plane_in = cfg_we ? cfg_data : plane_ff;

   assign ca = plane_ff[bfc_pkg::AOff +: bfc_pkg::CoefW];
   assign cb = plane_ff[bfc_pkg::BOff +: bfc_pkg::CoefW];
   assign cc = plane_ff[bfc_pkg::COff +: bfc_pkg::CoefW];
   assign cd = plane_ff[bfc_pkg::DOff +: bfc_pkg::DW];

   // farthest corner along the normal: all corners are outside iff it is
   assign sx = ca[bfc_pkg::CoefW-1] ? in_box.x_lo : in_box.x_hi;
   assign sy = cb[bfc_pkg::CoefW-1] ? in_box.y_lo : in_box.y_hi;
   assign sz = cc[bfc_pkg::CoefW-1] ? in_box.z_lo : in_box.z_hi;

   always_comb begin
      px = ca * sx;
      py = cb * sy;
      pz = cc * sz;
      dx = {{(bfc_pkg::SumW-bfc_pkg::DW-bfc_pkg::DShift){cd[bfc_pkg::DW-1]}},
            cd, {bfc_pkg::DShift{1'b0}}};
   end

   assign b_ready  = !b_v_ff || out_ready;
   assign a_ready  = !a_v_ff || b_ready;
   assign in_ready = a_ready;

   assign sum = bfc_pkg::SumW'(px_ff) + bfc_pkg::SumW'(py_ff)
              + bfc_pkg::SumW'(pz_ff) + pd_ff;

   always_comb begin
      a_v_in   = a_ready ? in_valid : a_v_ff;
      px_in    = a_ready ? px : px_ff;
      py_in    = a_ready ? py : py_ff;
      pz_in    = a_ready ? pz : pz_ff;
      pd_in    = a_ready ? dx : pd_ff;
      a_box_in = a_ready ? in_box : a_box_ff;

      b_v_in   = b_ready ? a_v_ff : b_v_ff;
      b_box_in = b_box_ff;
      if (b_ready) begin
         b_box_in        = a_box_ff;
         b_box_in.reject = a_box_ff.reject | sum[bfc_pkg::SumW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
      end else begin
         plane_ff <= plane_in;
         a_v_ff   <= a_v_in;
         b_v_ff   <= b_v_in;
      end
      px_ff    <= px_in;
      py_ff    <= py_in;
      pz_ff    <= pz_in;
      pd_ff    <= pd_in;
      a_box_ff <= a_box_in;
      b_box_ff <= b_box_in;
   end

   assign out_valid = b_v_ff;
   assign out_box   = b_box_ff;

endmodule

// ===== hw/rtl/box_frustum_cull_unit.sv =====
// Pipeline: 1 prep stage, then 2 stages in each of the 6 plane cells; the last
//   cell's sum stage register drives rsp_tvalid.
// Throughput: one box per cycle; each stage stalls only when the stage ahead is
//   full and not draining, so bubbles collapse under rsp_tready backpressure.
// Reset: synchronous, active high; clears all stage valids and the six plane
//   registers, so after reset every box is reported visible.
module box_frustum_cull_unit (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata, low bit up: center_x[23:0], center_y[23:0], center_z[23:0],
   //   edge_length[15:0]
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfc_pkg::ReqDataW-1:0]    req_tdata,
   // rsp_tdata, low bit up: visible, then 7 zero pad bits
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfc_pkg::RspDataW-1:0]    rsp_tdata,
   // plane writes: index 0..5 = right, left, bottom, top, near, far
   input  logic                            csr_wr_en,
   input  logic [bfc_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [bfc_pkg::CfgW-1:0]        csr_wr_data
);

   // chain[0] is the prep stage output, chain[i+1] the output of plane cell i
   logic             chain_valid [bfc_pkg::NumPlanes+1];
   logic             chain_ready [bfc_pkg::NumPlanes+1];
   bfc_pkg::box_type chain_box   [bfc_pkg::NumPlanes+1];
   logic             cell_we     [bfc_pkg::NumPlanes];

   // doubled corner extents, one register stage
   bfc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_box   (chain_box[0])
   );

   // one cell per plane; each ORs its verdict into the reject flag it hands on
   for (genvar i = 0; i < bfc_pkg::NumPlanes; i++) begin : g_cell
      // writes to indexes past the last plane match no cell and are dropped
      assign cell_we[i] = csr_wr_en && (csr_index == bfc_pkg::CsrIdxW'(i));

      bfc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cfg_we    (cell_we[i]),
         .cfg_data  (csr_wr_data),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_box    (chain_box[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_box   (chain_box[i+1])
      );
   end

   // last cell's sum stage register is the output register
   assign rsp_tvalid                       = chain_valid[bfc_pkg::NumPlanes];
   assign chain_ready[bfc_pkg::NumPlanes]  = rsp_tready;
   assign rsp_tdata = {{(bfc_pkg::RspDataW-1){1'b0}}, !chain_box[bfc_pkg::NumPlanes].reject};

endmodule

// ===== hw/rtl/bfc_checker.sv =====
module bfc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bfc_pkg::RspDataW-1:0]    rsp_tdata
);

   localparam int Depth = 1 + 2 * bfc_pkg::NumPlanes;
   localparam int CntW  = $clog2(Depth + 1);

   logic            req_xfer, rsp_xfer;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;

   // boxes in flight as seen on the ports
   always_comb begin
      cnt_in = cnt_ff;
      if (req_xfer && !rsp_xfer) begin
         cnt_in = cnt_ff + CntW'(1);
      end else if (rsp_xfer && !req_xfer) begin
         cnt_in = cnt_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer dropped or changed while stalled");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cnt_ff != '0)
      else $error("rsp transfer without a matching req transfer");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntW'(Depth))
      else $error("more boxes in flight than pipeline stages");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == '0 |-> req_tready)
      else $error("req side stalled with an empty pipeline");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[bfc_pkg::RspDataW-1:1] == '0)
      else $error("rsp pad bits not zero");

endmodule

bind box_frustum_cull_unit bfc_checker u_bfc_checker (.*);

// ===== sim/cull_checker.sv =====
`timescale 1ns / 100ps

module cull_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [bfc_pkg::ReqDataW-1:0] req_tdata,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [bfc_pkg::RspDataW-1:0] rsp_tdata,
   input  logic                         csr_wr_en,
   input  logic [bfc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [bfc_pkg::CfgW-1:0]     csr_wr_data,
   output int                           fail_count,
   output int                           pending_count
);

   // expected verdicts in transfer order; far deeper than the pipe holds
   localparam int RingDepth = 64;

   logic [bfc_pkg::CfgW-1:0] plane_regs [bfc_pkg::NumPlanes];
   bit                       exp_ring [RingDepth];
   int                       wr_cnt = 0;
   int                       rd_cnt = 0;
   bit                       exp_visible;
   int                       fail_n = 0;
   int                       pend_n = 0;

   assign fail_count    = fail_n;
   assign pending_count = pend_n;

   // box spans [c - e/2, c + e/2] in x and z, [c, c + e] in y; doubled coords
   function automatic bit predict_visible(input logic [bfc_pkg::ReqDataW-1:0] box);
      longint xs [2];
      longint ys [2];
      longint zs [2];
      longint cx, cy, cz, e;
      longint a, b, c, d, dot;
      int     n_out;
      bit     vis;
      cx    = $signed(box[0 +: bfc_pkg::InW]);
      cy    = $signed(box[bfc_pkg::CyOff +: bfc_pkg::InW]);
      cz    = $signed(box[bfc_pkg::CzOff +: bfc_pkg::InW]);
      e     = box[bfc_pkg::EdgeOff +: bfc_pkg::EdgeW];
      xs[0] = 2 * cx - e;
      xs[1] = 2 * cx + e;
      ys[0] = 2 * cy;
      ys[1] = 2 * cy + 2 * e;
      zs[0] = 2 * cz - e;
      zs[1] = 2 * cz + e;
      vis   = 1'b1;
      for (int p = 0; p < bfc_pkg::NumPlanes; p++) begin
         a = $signed(plane_regs[p][bfc_pkg::AOff +: bfc_pkg::CoefW]);
         b = $signed(plane_regs[p][bfc_pkg::BOff +: bfc_pkg::CoefW]);
         c = $signed(plane_regs[p][bfc_pkg::COff +: bfc_pkg::CoefW]);
         d = $signed(plane_regs[p][bfc_pkg::DOff +: bfc_pkg::DW]);
         d = d <<< bfc_pkg::DShift;
         n_out = 0;
         for (int k = 0; k < 8; k++) begin
            dot = a * xs[k & 1] + b * ys[(k >> 1) & 1] + c * zs[(k >> 2) & 1] + d;
            if (dot < 0) n_out++;
         end
         if (n_out == 8) vis = 1'b0;
      end
      return vis;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (plane_regs[i]) plane_regs[i] = '0;
         wr_cnt = 0;
         rd_cnt = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (wr_cnt == rd_cnt) begin
               if (fail_n < 10)
                  $display("%0t: unexpected rsp transfer, tdata %h", $realtime, rsp_tdata);
               fail_n++;
            end else begin
               exp_visible = exp_ring[rd_cnt % RingDepth];
               rd_cnt++;
               if (rsp_tdata !== {{(bfc_pkg::RspDataW-1){1'b0}}, exp_visible}) begin
                  if (fail_n < 10)
                     $display("%0t: visible expected %0d, got tdata %h",
                              $realtime, exp_visible, rsp_tdata);
                  fail_n++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (wr_cnt - rd_cnt >= RingDepth) begin
               if (fail_n < 10)
                  $display("%0t: too many req transfers in flight", $realtime);
               fail_n++;
            end
            exp_ring[wr_cnt % RingDepth] = predict_visible(req_tdata);
            wr_cnt++;
         end
         // indexes past the table are dropped by the block
         if (csr_wr_en && csr_index < bfc_pkg::NumPlanes)
            plane_regs[csr_index] = csr_wr_data;
      end
      pend_n = wr_cnt - rd_cnt;
   end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import bfc_pkg::*;

   // plane register indexes
   localparam logic [CsrIdxW-1:0] IdxRight  = 3'd0;
   localparam logic [CsrIdxW-1:0] IdxLeft   = 3'd1;
   localparam logic [CsrIdxW-1:0] IdxBottom = 3'd2;
   localparam logic [CsrIdxW-1:0] IdxTop    = 3'd3;
   localparam logic [CsrIdxW-1:0] IdxNear   = 3'd4;
   localparam logic [CsrIdxW-1:0] IdxFar    = 3'd5;
   localparam logic [CsrIdxW-1:0] IdxSpare0 = 3'd6;   // past the table
   localparam logic [CsrIdxW-1:0] IdxSpare1 = 3'd7;

   localparam int WatchdogLimit = 2000;
   localparam int ItemsPerPhase = 135;
   localparam int NumPhases     = 7;

   localparam logic [InW-1:0] CMax = 24'h7F_FFFF;
   localparam logic [InW-1:0] CMin = 24'h80_0000;

   // Q1.11 unity and the coefficient extremes
   localparam int One     = 2048;
   localparam int CoefMax = 4095;
   localparam int CoefMin = -4096;
   localparam int DMax    = (1 << 24) - 1;
   localparam int DMin    = -(1 << 24);

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_CYCLIC
   } ready_mode_e;

   typedef enum int {
      CFG_BOX_FRUSTUM,
      CFG_SPARSE_RANDOM,
      CFG_TILTED,
      CFG_DENSE_RANDOM,
      CFG_EXTREMES
   } cfg_kind_e;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [ReqDataW-1:0] req_tdata   = '0;
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RspDataW-1:0] rsp_tdata;
   logic                csr_wr_en   = 1'b0;
   logic [CsrIdxW-1:0]  csr_index   = '0;
   logic [CfgW-1:0]     csr_wr_data = '0;

   int fail_count;
   int pending_count;

   // 8 ns period
   always #4 clock = ~clock;

   box_frustum_cull_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // watches both channels and the plane writes, predicts visible per box
   cull_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // ---------------------------------------------------------------------
   // Receiver: the stall pattern periodically redraws its mode at random. Always-ready
   // stretches let the pipe run full rate; sparse mode backs it up.
   // ---------------------------------------------------------------------
   ready_mode_e ready_mode = READY_ALWAYS;
   int          ready_tick = 0;

   always @(negedge clock) begin
      ready_tick++;
      if (ready_tick % 97 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
         READY_SPARSE: rsp_tready <= ($urandom_range(0, 3) == 0);
         default:      rsp_tready <= ((ready_tick % 7) < 4);
      endcase
   end

   // ---------------------------------------------------------------------
   // Watchdog: too long without any transfer on either channel = hang.
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("box_frustum_cull_unit: mismatch");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Packing helpers
   // ---------------------------------------------------------------------
   function automatic logic [CfgW-1:0] make_plane(input int a, input int b,
                                                  input int c, input int d);
      return {d[DW-1:0], c[CoefW-1:0], b[CoefW-1:0], a[CoefW-1:0]};
   endfunction

   function automatic logic [ReqDataW-1:0] pack_box(input logic [InW-1:0] cx,
                                                    input logic [InW-1:0] cy,
                                                    input logic [InW-1:0] cz,
                                                    input logic [EdgeW-1:0] e);
      return {e, cz, cy, cx};
   endfunction

   // mostly boxes near the origin at a random scale, some full-range noise
   function automatic logic [ReqDataW-1:0] random_box();
      logic [95:0]      raw;
      logic [InW-1:0]   c [3];
      logic [EdgeW-1:0] e;
      int               span;
      raw = {$urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 4) == 0) return raw[ReqDataW-1:0];
      span = 1 << $urandom_range(6, 22);
      foreach (c[i]) c[i] = InW'($urandom_range(0, 2 * span) - span);
      e = EdgeW'($urandom_range(0, (1 << $urandom_range(1, 16)) - 1));
      return pack_box(c[0], c[1], c[2], e);
   endfunction

   // ---------------------------------------------------------------------
   // Drivers: everything changes on the falling edge, transfers complete on
   // the rising edge. req_tvalid stays high across back-to-back boxes.
   // ---------------------------------------------------------------------
   task automatic send_box(input logic [ReqDataW-1:0] box);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= box;
      do @(posedge clock); while (!req_tready);
   endtask

   // idle gap; tdata wiggles while valid is low
   task automatic idle_for(input int n);
      logic [95:0] junk;
      repeat (n) begin
         @(negedge clock);
         junk = {$urandom(), $urandom(), $urandom()};
         req_tvalid <= 1'b0;
         req_tdata  <= junk[ReqDataW-1:0];
      end
   endtask

   // hold off until every box in flight has come back
   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CsrIdxW-1:0] idx, input logic [CfgW-1:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
   endtask

   task automatic csr_release();
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // rewrite all six planes; only called with the pipe drained
   task automatic load_planes(input cfg_kind_e kind);
      logic [CfgW-1:0] pl [NumPlanes];
      int              co [3];
      int              lim;
      int              mag;
      int              pick;
      lim = 0;
      foreach (pl[p]) pl[p] = '0;
      case (kind)
         CFG_BOX_FRUSTUM: begin
            // axis-aligned slab per axis: -lim <= coord <= lim
            for (int p = 0; p < NumPlanes; p++) begin
               co = '{0, 0, 0};
               co[p / 2] = (p % 2 == 0) ? -One : One;
               if (p % 2 == 0) lim = $urandom_range(64, 1 << 22);
               pl[p] = make_plane(co[0], co[1], co[2], lim);
            end
         end
         CFG_SPARSE_RANDOM: begin
            repeat ($urandom_range(1, 2))
               pl[$urandom_range(0, NumPlanes - 1)] = {$urandom(), $urandom()};
         end
         CFG_TILTED: begin
            foreach (pl[p]) begin
               if ($urandom_range(0, 3) != 0) begin
                  mag = $urandom_range(8, 23);
                  lim = $urandom_range(0, 1 << mag);
                  if ($urandom_range(0, 3) == 0) lim = -lim;
                  pl[p] = make_plane($urandom_range(0, 8191) - 4096,
                                     $urandom_range(0, 8191) - 4096,
                                     $urandom_range(0, 8191) - 4096, lim);
               end
            end
         end
         CFG_DENSE_RANDOM: begin
            foreach (pl[p]) pl[p] = {$urandom(), $urandom()};
            pl[$urandom_range(0, NumPlanes - 1)] = '1;
         end
         default: begin
            foreach (pl[p]) begin
               pick = $urandom_range(0, 4);
               case (pick)
                  0:       pl[p] = '0;
                  1:       pl[p] = '1;
                  2:       pl[p] = make_plane(CoefMin, CoefMin, CoefMin, DMin);
                  3:       pl[p] = make_plane(CoefMax, CoefMax, CoefMax, DMax);
                  default: pl[p] = make_plane(CoefMax, CoefMin, CoefMax, 0);
               endcase
            end
         end
      endcase
      for (int p = 0; p < NumPlanes; p++) csr_write(CsrIdxW'(p), pl[p]);
      // stray writes past the table must not land anywhere
      if ($urandom_range(0, 1) == 1)
         csr_write($urandom_range(0, 1) ? IdxSpare0 : IdxSpare1, {$urandom(), $urandom()});
      csr_release();
   endtask

   // bursty sender with occasional full drains
   task automatic run_stream(input int n_items);
      int sent;
      int burst;
      sent = 0;
      while (sent < n_items) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < n_items; k++) begin
            send_box(random_box());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 6));
         if ($urandom_range(0, 39) == 0) drain_results();
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // planes at reset are all zero: everything is visible
      send_box(pack_box(CMax, CMax, CMax, 16'hFFFF));
      send_box(pack_box(CMin, CMin, CMin, 16'h0000));
      send_box(pack_box(24'd0, 24'd0, 24'd0, 16'h0000));
      send_box(pack_box(CMin, CMax, CMin, 16'hFFFF));

      // left plane x >= 0: a corner landing exactly on it counts as inside
      drain_results();
      csr_write(IdxLeft, make_plane(One, 0, 0, 0));
      csr_write(IdxSpare0, '1);
      csr_write(IdxSpare1, '1);
      csr_release();
      send_box(pack_box(-24'sd256, 24'd0, 24'd0, 16'd512));   // high corner on plane
      send_box(pack_box(-24'sd257, 24'd0, 24'd0, 16'd512));   // all just outside
      send_box(pack_box(-24'sd256, 24'd0, 24'd0, 16'd0));     // zero edge, outside
      send_box(pack_box(24'd0, 24'd0, 24'd0, 16'd0));         // point on plane

      // bottom plane y >= 0: box grows upward from its base
      drain_results();
      csr_write(IdxLeft, '0);
      csr_write(IdxBottom, make_plane(0, One, 0, 0));
      csr_release();
      send_box(pack_box(24'd0, 24'd0, 24'd0, 16'd100));
      send_box(pack_box(24'd0, -24'sd1, 24'd0, 16'd0));
      send_box(pack_box(24'd0, -24'sd1, 24'd0, 16'd2));

      // coefficient and offset extremes, widest products
      drain_results();
      csr_write(IdxBottom, '0);
      csr_write(IdxRight, '0);
      csr_write(IdxTop, '0);
      csr_write(IdxNear, make_plane(CoefMin, CoefMin, CoefMin, DMin));
      csr_write(IdxFar, make_plane(CoefMax, CoefMax, CoefMax, DMax));
      csr_release();
      send_box(pack_box(CMax, CMax, CMax, 16'hFFFF));
      send_box(pack_box(CMin, CMin, CMin, 16'h0000));
      send_box(pack_box(24'd0, 24'd0, 24'd0, 16'd0));
      send_box(pack_box(CMin, CMin, CMin, 16'hFFFF));

      // random phases, each with its own plane set
      for (int ph = 0; ph < NumPhases; ph++) begin
         drain_results();
         load_planes(cfg_kind_e'(ph % 5));
         run_stream(ItemsPerPhase);
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("box_frustum_cull_unit: match");
      end else begin
         $display("box_frustum_cull_unit: mismatch");
      end
      $finish;
   end

endmodule
